@@ hdl/selective_repeat_fragment_receiver_defines.svh @@
// Assertion macros used by the receiver's RTL.
`ifndef SELECTIVE_REPEAT_FRAGMENT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_FRAGMENT_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SRFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("receiver assertion failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SRFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("receiver assertion failed");

`endif

@@ hdl/srfr_pkg.sv @@
// Types, constants and helper functions of the selective-repeat fragment receiver.
package srfr_pkg;

  localparam int WINDOW_BUFFERS = 8;
  localparam int MAX_SEQ        = 15;
  localparam int MAX_FRAGMENTS  = 16;

  localparam int SEQ_W   = 4;
  localparam int FRAG_W  = 4;
  localparam int LEN_W   = 12;
  localparam int BYTES_W = 16;
  localparam int CNT_W   = 5;
  localparam int BUF_W   = $clog2(WINDOW_BUFFERS);

  typedef enum logic [1:0] {
    KIND_NACK    = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_ACK     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NACK,
    S_UPD,
    S_LRD,
    S_LCHK,
    S_FIN
  } state_e;

  // One receive buffer; contig uses all ones for "no contiguous prefix".
  typedef struct packed {
    logic [MAX_FRAGMENTS-1:0] bitmap;
    logic [CNT_W-1:0]         total;
    logic [LEN_W-1:0]         size;
    logic [BYTES_W-1:0]       bytes;
    logic                     complete;
    logic [CNT_W-1:0]         contig;
  } entry_t;

  typedef struct packed {
    kind_e              kind;
    logic [SEQ_W-1:0]   nack_seq;
    logic [FRAG_W-1:0]  nack_frag;
    logic [BYTES_W-1:0] deliver_len;
    logic               ack_valid;
    logic [SEQ_W-1:0]   ack_seq;
    logic [FRAG_W-1:0]  ack_frag;
  } result_t;

  localparam entry_t ENTRY_RESET = '{
    bitmap:   '0,
    total:    '0,
    size:     '0,
    bytes:    '0,
    complete: 1'b0,
    contig:   '1
  };

  function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
    seq_next = (s == SEQ_W'(MAX_SEQ)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_prev(input logic [SEQ_W-1:0] s);
    seq_prev = (s == '0) ? SEQ_W'(MAX_SEQ) : s - 1'b1;
  endfunction

  function automatic logic [BUF_W-1:0] buf_of(input logic [SEQ_W-1:0] s);
    buf_of = BUF_W'(s % SEQ_W'(WINDOW_BUFFERS));
  endfunction

  // True when b lies in [a, c) counted modulo the sequence space.
  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    logic c1;
    logic c2;
    logic c3;
    c1 = b < c;
    c2 = c < a;
    c3 = a <= b;
    in_window = (c3 && c1) || (c2 && c3) || (c1 && c2);
  endfunction

endpackage

@@ hdl/selective_repeat_fragment_receiver.sv @@
// Top level of the selective-repeat fragment receiver.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid_i/tready_o     tdata: seq, fragment, length; tlast: is_last
// m_axis    out  m_axis_tvalid_o/tready_i     tdata: nack, length, ack; tuser: kind; tlast
//
// A dropped fragment passes the nack and update states and ends; a stored one also reads
// and checks the expected buffer, and each frame delivered in order repeats that read and check.
// Reset marks every buffer empty at once through one valid bit per buffer.
// A result-side stall holds the sequencer only while a result must move on and both
// the output register and the pending register are full.
`include "selective_repeat_fragment_receiver_defines.svh"

module selective_repeat_fragment_receiver
  import srfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // seq_number[3:0], fragment_index[7:4],
                                        // payload_len[19:8], zero fill above
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // nack_seq[3:0], nack_fragment[7:4],
                                        // deliver_len[23:8], ack_valid[24],
                                        // ack_seq[28:25], ack_fragment[32:29], zeros above
  output logic [1:0]  m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o    // last_result
);

  // Sequencer state and the item being worked on.
  state_e             state_q, state_d;
  logic [SEQ_W-1:0]   seq_q;
  logic [FRAG_W-1:0]  frag_q;
  logic               last_q;
  logic [LEN_W-1:0]   len_q;

  // Window state held in flip-flops.
  logic [SEQ_W-1:0]   expected_q;
  logic [SEQ_W-1:0]   window_end_q;
  logic               nack_allowed_q;
  logic [CNT_W-1:0]   last_full_q;
  logic               delivered_q;
  logic               ackdue_q, ackdue_d;

  // Buffer memory with one valid bit per buffer; an invalid buffer reads as empty.
  entry_t                    mem_q [WINDOW_BUFFERS];
  logic [WINDOW_BUFFERS-1:0] valid_q;
  entry_t                    rda_q, rdb_q;
  logic                      rdav_q, rdbv_q;
  entry_t                    ent_a, ent_b;

  // Result path: a pending register keeps the newest result until it is known
  // whether it is the last one of the item.
  logic    p_valid_q;
  result_t p_res_q;
  logic    o_valid_q;
  result_t o_res_q;
  logic    o_last_q;

  logic        in_accept;
  logic        frag_ok;
  logic        o_ready;
  logic        can_push;
  logic        emit_req;
  result_t     emit_res;
  logic        fin_req;
  logic        go;
  logic        mem_we;
  logic        deliver;
  logic        nack_need;
  result_t     nack_res;
  logic        ack_valid;
  logic [SEQ_W-1:0]  ack_seq;
  logic [FRAG_W-1:0] ack_frag;
  logic        accept_frag;
  entry_t      upd;
  logic [MAX_FRAGMENTS:0] ext;
  logic [MAX_FRAGMENTS:0] low_zero;
  logic [CNT_W-1:0]       run;
  logic [CNT_W-1:0]       run_cap;
  logic [BUF_W-1:0]       addr_a;
  logic [BUF_W-1:0]       addr_b;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign frag_ok         = CNT_W'(s_axis_tdata_i[7:4]) < CNT_W'(MAX_FRAGMENTS);

  assign addr_a = buf_of(s_axis_tdata_i[3:0]);
  assign addr_b = buf_of(expected_q);

  assign ent_a = rdav_q ? rda_q : ENTRY_RESET;
  assign ent_b = rdbv_q ? rdb_q : ENTRY_RESET;

  // Piggybacked acknowledgement, taken from the expected buffer as last read.
  always_comb begin
    ack_valid = 1'b0;
    ack_seq   = '0;
    ack_frag  = '0;
    if (!ent_b.contig[CNT_W-1]) begin
      ack_valid = 1'b1;
      ack_seq   = expected_q;
      ack_frag  = ent_b.contig[FRAG_W-1:0];
    end else if (!last_full_q[CNT_W-1]) begin
      ack_valid = 1'b1;
      ack_seq   = seq_prev(expected_q);
      ack_frag  = last_full_q[FRAG_W-1:0];
    end
  end

  // A gap is reported for a frame out of order, or for a missing earlier fragment.
  always_comb begin
    nack_need = 1'b0;
    nack_res  = '0;
    nack_res.kind      = KIND_NACK;
    nack_res.ack_valid = ack_valid;
    nack_res.ack_seq   = ack_seq;
    nack_res.ack_frag  = ack_frag;
    if (seq_q != expected_q) begin
      nack_need         = nack_allowed_q;
      nack_res.nack_seq = (frag_q == '0) ? seq_prev(seq_q) : seq_q;
    end else begin
      nack_need          = nack_allowed_q && (frag_q != '0) && !ent_a.bitmap[frag_q - 1'b1];
      nack_res.nack_seq  = seq_q;
      nack_res.nack_frag = frag_q - 1'b1;
    end
  end

  // Buffer update for an accepted fragment, with the contiguous prefix found from the
  // lowest clear bit of the new bitmap.
  always_comb begin
    accept_frag = in_window(expected_q, seq_q, window_end_q) && !ent_a.bitmap[frag_q];
    upd = ent_a;
    if (!last_q) begin
      upd.size = len_q;
    end else begin
      upd.total = CNT_W'(frag_q) + 1'b1;
      if (frag_q == '0) begin
        upd.size = len_q;
      end
    end
    if (upd.size != '0) begin
      upd.bitmap = upd.bitmap | (MAX_FRAGMENTS'(1) << frag_q);
      upd.bytes  = upd.bytes + BYTES_W'(len_q);
    end
    ext      = {1'b0, upd.bitmap};
    low_zero = ~ext & (ext + 1'b1);
    run      = '0;
    for (int i = 0; i <= MAX_FRAGMENTS; i++) begin
      if (low_zero[i]) begin
        run = run | CNT_W'(i);
      end
    end
    run_cap = (run >= upd.total) ? upd.total : run;
    if (upd.total != '0) begin
      upd.complete = run >= upd.total;
      upd.contig   = run_cap - 1'b1;
    end
    ackdue_d = accept_frag && ($signed(upd.contig) > $signed(ent_a.contig));
  end

  assign o_ready  = !o_valid_q || m_axis_tready_i;
  assign can_push = !p_valid_q || o_ready;

  // Outputs of the sequencer.
  always_comb begin
    emit_req = 1'b0;
    emit_res = '0;
    fin_req  = 1'b0;
    mem_we   = 1'b0;
    deliver  = 1'b0;
    case (state_q)
      S_NACK: begin
        emit_req = nack_need;
        emit_res = nack_res;
      end
      S_UPD: begin
        mem_we = accept_frag;
      end
      S_LCHK: begin
        if (ent_b.complete) begin
          emit_req             = 1'b1;
          emit_res.kind        = KIND_DELIVER;
          emit_res.deliver_len = ent_b.bytes;
          deliver              = can_push;
        end else if (delivered_q || ackdue_q) begin
          emit_req           = 1'b1;
          emit_res.kind      = KIND_ACK;
          emit_res.ack_valid = ack_valid;
          emit_res.ack_seq   = ack_seq;
          emit_res.ack_frag  = ack_frag;
        end
      end
      S_FIN: begin
        fin_req = 1'b1;
      end
      default: begin
      end
    endcase
    go = emit_req ? can_push : (fin_req ? (!p_valid_q || o_ready) : 1'b1);
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && frag_ok) begin
          state_d = S_NACK;
        end
      end
      S_NACK: begin
        if (go) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        state_d = accept_frag ? S_LRD : S_FIN;
      end
      S_LRD: begin
        state_d = S_LCHK;
      end
      S_LCHK: begin
        if (go) begin
          state_d = ent_b.complete ? S_LRD : S_FIN;
        end
      end
      S_FIN: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory array: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[buf_of(seq_q)] <= upd;
    end
    if (in_accept) begin
      rda_q <= mem_q[addr_a];
    end
    rdb_q <= mem_q[addr_b];
  end

  // Item payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      seq_q  <= s_axis_tdata_i[3:0];
      frag_q <= s_axis_tdata_i[7:4];
      last_q <= s_axis_tlast_i;
      len_q  <= s_axis_tdata_i[19:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      expected_q     <= '0;
      window_end_q   <= SEQ_W'(WINDOW_BUFFERS);
      nack_allowed_q <= 1'b1;
      last_full_q    <= '1;
      delivered_q    <= 1'b0;
      ackdue_q       <= 1'b0;
      valid_q        <= '0;
      rdav_q         <= 1'b0;
      rdbv_q         <= 1'b0;
      p_valid_q      <= 1'b0;
      p_res_q        <= '0;
      o_valid_q      <= 1'b0;
      o_res_q        <= '0;
      o_last_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        rdav_q <= valid_q[addr_a];
      end
      rdbv_q <= valid_q[addr_b];

      if (state_q == S_NACK && go && nack_need) begin
        nack_allowed_q <= 1'b0;
      end
      if (state_q == S_UPD) begin
        delivered_q <= 1'b0;
        ackdue_q    <= ackdue_d;
      end
      if (mem_we) begin
        valid_q[buf_of(seq_q)] <= 1'b1;
      end

      // In-order delivery frees the expected buffer and slides the window.
      if (deliver) begin
        valid_q[addr_b] <= 1'b0;
        last_full_q     <= ent_b.contig;
        expected_q      <= seq_next(expected_q);
        window_end_q    <= seq_next(window_end_q);
        nack_allowed_q  <= 1'b1;
        delivered_q     <= 1'b1;
      end

      // The pending result moves on once a newer one arrives or the item ends.
      if (emit_req && can_push) begin
        if (p_valid_q) begin
          o_valid_q <= 1'b1;
          o_res_q   <= p_res_q;
          o_last_q  <= 1'b0;
        end else if (m_axis_tready_i) begin
          o_valid_q <= 1'b0;
        end
        p_valid_q <= 1'b1;
        p_res_q   <= emit_res;
      end else if (fin_req && p_valid_q && o_ready) begin
        o_valid_q <= 1'b1;
        o_res_q   <= p_res_q;
        o_last_q  <= 1'b1;
        p_valid_q <= 1'b0;
      end else if (m_axis_tready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tuser_o  = o_res_q.kind;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tdata_o  = {7'd0, o_res_q.ack_frag, o_res_q.ack_seq, o_res_q.ack_valid,
                            o_res_q.deliver_len, o_res_q.nack_frag, o_res_q.nack_seq};

  // The pending register is always drained before a new item is taken.
  `SRFR_ASSERT_IMP(a_idle_drained, s_axis_tready_o, !p_valid_q)
  // The window end stays a fixed distance ahead of the expected frame.
  `SRFR_ASSERT_IMP(a_window_span, 1'b1,
    window_end_q == SEQ_W'((expected_q + SEQ_W'(WINDOW_BUFFERS)) % (MAX_SEQ + 1)))
  // The expected frame only moves during the delivery check.
  `SRFR_ASSERT_NXT(a_expected_moves, state_q != S_LCHK, $stable(expected_q))

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the selective-repeat fragment receiver.
module tb;
  import srfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One expected or observed result item.
  typedef struct {
    kind_e             kind;
    logic [3:0]        nack_seq;
    logic [3:0]        nack_frag;
    logic [15:0]       deliver_len;
    logic              ack_valid;
    logic [3:0]        ack_seq;
    logic [3:0]        ack_frag;
    logic              last;
  } rx_result_t;

  int unsigned mismatch_count = 0;

  // Prints one line for a mismatch and counts it.
  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Holds a private copy of the receiver state and predicts the result items
  // that each accepted fragment should cause.
  class window_scoreboard;
    logic [3:0]  exp_seq;
    logic [3:0]  win_end;
    bit          nack_ok;
    int          last_full;
    logic [15:0] bitmap [8];
    int unsigned total [8];
    logic [11:0] fsize [8];
    logic [15:0] rbytes [8];
    bit          done [8];
    int          contig [8];
    rx_result_t  pending_results[$];

    function new();
      exp_seq = 0;
      win_end = 4'(WINDOW_BUFFERS);
      nack_ok = 1;
      last_full = -1;
      for (int i = 0; i < 8; i++) begin
        bitmap[i] = '0;
        total[i] = 0;
        fsize[i] = '0;
        rbytes[i] = '0;
        done[i] = 0;
        contig[i] = -1;
      end
    endfunction

    function automatic bit window_holds(logic [3:0] a, logic [3:0] b, logic [3:0] c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function automatic rx_result_t make(kind_e k, logic [3:0] ns, logic [3:0] nf,
                                        logic [15:0] dl, bit with_ack);
      rx_result_t r;
      int eb;
      eb = exp_seq % 8;
      r.kind = k;
      r.nack_seq = ns;
      r.nack_frag = nf;
      r.deliver_len = dl;
      r.ack_valid = 0;
      r.ack_seq = 0;
      r.ack_frag = 0;
      r.last = 0;
      if (with_ack) begin
        if (contig[eb] >= 0) begin
          r.ack_valid = 1;
          r.ack_seq = exp_seq;
          r.ack_frag = 4'(contig[eb]);
        end else if (last_full >= 0) begin
          r.ack_valid = 1;
          r.ack_seq = exp_seq - 4'd1;
          r.ack_frag = 4'(last_full);
        end
      end
      return r;
    endfunction

    // Notes an accepted fragment and queues what it should cause.
    function void note_fragment(logic [3:0] seq, logic [3:0] frag, bit is_last,
                                logic [11:0] len);
      rx_result_t step_results[$];
      int b;
      int prev;
      int eb;
      bit delivered;
      b = seq % 8;
      delivered = 0;
      if (nack_ok) begin
        if (seq != exp_seq) begin
          step_results.push_back(make(KIND_NACK, (frag == 0) ? seq - 4'd1 : seq, 0, 0, 1));
          nack_ok = 0;
        end else if (frag >= 1 && !bitmap[b][frag-1]) begin
          step_results.push_back(make(KIND_NACK, seq, frag - 4'd1, 0, 1));
          nack_ok = 0;
        end
      end
      if (window_holds(exp_seq, seq, win_end) && !bitmap[b][frag]) begin
        if (!is_last) fsize[b] = len;
        else begin
          total[b] = frag + 1;
          if (frag == 0) fsize[b] = len;
        end
        if (fsize[b] != 0) begin
          bitmap[b][frag] = 1'b1;
          rbytes[b] = rbytes[b] + 16'(len);
        end
        prev = contig[b];
        if (total[b] > 0) begin
          done[b] = 1;
          contig[b] = -1;
          for (int f = 0; f < total[b]; f++) begin
            if (!bitmap[b][f]) begin
              done[b] = 0;
              break;
            end
            contig[b] = f;
          end
        end
        for (int it = 0; it < 8; it++) begin
          eb = exp_seq % 8;
          if (!done[eb]) break;
          delivered = 1;
          step_results.push_back(make(KIND_DELIVER, 0, 0, rbytes[eb], 0));
          nack_ok = 1;
          rbytes[eb] = 0;
          done[eb] = 0;
          bitmap[eb] = 0;
          fsize[eb] = 0;
          total[eb] = 0;
          last_full = contig[eb];
          contig[eb] = -1;
          exp_seq = exp_seq + 4'd1;
          win_end = win_end + 4'd1;
        end
        if (delivered || prev < contig[b])
          step_results.push_back(make(KIND_ACK, 0, 0, 0, 1));
      end
      if (step_results.size() > 0) step_results[$].last = 1;
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endfunction

    // Compares one observed result with the oldest expectation.
    task check_result(rx_result_t got);
      rx_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d", got.kind));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.nack_seq !== want.nack_seq)
        report($sformatf("nack_seq %0d, want %0d", got.nack_seq, want.nack_seq));
      if (got.nack_frag !== want.nack_frag)
        report($sformatf("nack_fragment %0d, want %0d", got.nack_frag, want.nack_frag));
      if (got.deliver_len !== want.deliver_len)
        report($sformatf("deliver_len %0d, want %0d", got.deliver_len, want.deliver_len));
      if (got.ack_valid !== want.ack_valid)
        report($sformatf("ack_valid %0b, want %0b", got.ack_valid, want.ack_valid));
      if (got.ack_seq !== want.ack_seq)
        report($sformatf("ack_seq %0d, want %0d", got.ack_seq, want.ack_seq));
      if (got.ack_frag !== want.ack_frag)
        report($sformatf("ack_fragment %0d, want %0d", got.ack_frag, want.ack_frag));
      if (got.last !== want.last)
        report($sformatf("last_result %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  selective_repeat_fragment_receiver dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  window_scoreboard board = new();
  bit          hold_off = 0;   // set while the long receiver stall is wanted
  int unsigned cycle_count = 0;

  // Offers one fragment after a random gap and waits until it is taken; the valid
  // line stays up after the handshake until the next falling edge decides.
  task automatic send_fragment(input logic [3:0] seq, input logic [3:0] frag,
                               input bit is_last, input logic [11:0] len);
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i <= {4'd0, len, frag, seq};
    s_axis_tlast_i <= is_last;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_fragment(seq, frag, is_last, len);
  endtask

  // Sends a whole frame in a shuffled or ordered fragment order.
  task automatic send_frame(input logic [3:0] seq, input int unsigned nfrag,
                            input bit shuffle);
    int unsigned order[$];
    logic [11:0] size;
    size = 12'($urandom_range(1, 4095));
    for (int i = 0; i < nfrag; i++) order.push_back(i);
    if (shuffle) order.shuffle();
    foreach (order[i])
      send_fragment(seq, 4'(order[i]), order[i] == nfrag - 1,
                    (order[i] == nfrag - 1 && nfrag > 1) ? 12'($urandom) : size);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_side
    rx_result_t got;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 0;
      end
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.kind = kind_e'(m_axis_tuser_o);
      got.nack_seq = m_axis_tdata_o[3:0];
      got.nack_frag = m_axis_tdata_o[7:4];
      got.deliver_len = m_axis_tdata_o[23:8];
      got.ack_valid = m_axis_tdata_o[24];
      got.ack_seq = m_axis_tdata_o[28:25];
      got.ack_frag = m_axis_tdata_o[32:29];
      got.last = m_axis_tlast_o;
      board.check_result(got);
    end
  end

  // Watchdog: a generous limit over the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("selective_repeat_fragment_receiver: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned nf;
    logic [3:0] next_seq;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: gaps, zero lengths, unknown size, extremes and duplicates.
    send_fragment(4'd0, 4'd1, 1'b0, 12'd4095);     // gap before fragment 1
    send_fragment(4'd3, 4'd0, 1'b0, 12'd10);       // frame ahead of expected
    send_fragment(4'd0, 4'd2, 1'b1, 12'd7);        // last fragment
    send_fragment(4'd0, 4'd0, 1'b0, 12'd4095);     // completes frame 0
    send_fragment(4'd1, 4'd15, 1'b1, 12'd0);       // last before size is known
    send_fragment(4'd1, 4'd0, 1'b0, 12'd0);        // zero length, still unknown
    send_fragment(4'd1, 4'd0, 1'b1, 12'd5);        // single-fragment frame
    send_fragment(4'd1, 4'd0, 1'b1, 12'd5);        // outside the window now
    send_fragment(4'd12, 4'd15, 1'b0, 12'd4095);   // far outside the window
    send_fragment(4'd2, 4'd0, 1'b0, 12'd2048);
    send_fragment(4'd2, 4'd0, 1'b0, 12'd1);        // duplicate fragment
    send_fragment(4'd2, 4'd1, 1'b1, 12'd4095);
    send_fragment(4'd4, 4'd0, 1'b1, 12'd3);        // buffered out of order
    send_fragment(4'd3, 4'd1, 1'b1, 12'd9);        // releases frames 3 and 4
    next_seq = 4'd5;
    sent = 14;

    // Long receiver hold-off while frames keep arriving.
    hold_off = 1;
    for (int i = 0; i < 6; i++) begin
      send_frame(next_seq, 3, 0);
      next_seq = next_seq + 4'd1;
      sent += 3;
    end

    // Random part: mostly well-formed frames, some noise.
    while (sent < 310) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_fragment(4'($urandom), 4'($urandom), 1'($urandom), 12'($urandom));
          sent++;
        end
        2: begin
          // Frame one ahead, then the expected one, to exercise reordering.
          nf = $urandom_range(1, 3);
          send_frame(board.exp_seq + 4'd1, nf, 1);
          sent += nf;
          nf = $urandom_range(1, 3);
          send_frame(board.exp_seq, nf, 1);
          sent += nf;
        end
        9: begin
          send_frame(board.exp_seq, 16, $urandom_range(0, 1));
          sent += 16;
        end
        default: begin
          nf = $urandom_range(1, 4);
          send_frame(board.exp_seq, nf, $urandom_range(0, 1));
          sent += nf;
        end
      endcase
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && !m_axis_tvalid_o) begin
      $display("selective_repeat_fragment_receiver: match");
    end else begin
      if (m_axis_tvalid_o) report("result left over at the end");
      $display("selective_repeat_fragment_receiver: mismatch");
    end
    $finish;
  end
endmodule
